[hw/rtl/oas_pkg.sv]
package oas_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_FORWARD = 3'd1,
        MODE_REVERSE = 3'd2,
        MODE_PAUSE   = 3'd3,
        MODE_TURNING = 3'd4,
        MODE_BYPASS  = 3'd5,
        MODE_HEADING = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        OBS_NONE  = 2'd0,
        OBS_FRONT = 2'd1,
        OBS_BOTH  = 2'd2,
        OBS_SIDE  = 2'd3
    } t_obs;

    localparam logic [2:0] CMD_STOP   = 3'd0;
    localparam logic [2:0] CMD_FWD    = 3'd1;
    localparam logic [2:0] CMD_REV    = 3'd2;
    localparam logic [2:0] CMD_TURN_L = 3'd3;
    localparam logic [2:0] CMD_TURN_R = 3'd4;
    localparam logic [2:0] CMD_YAW0   = 3'd5;

    localparam logic [2:0] REG_REVERSE_TIME  = 3'd0;
    localparam logic [2:0] REG_PAUSE_TIME    = 3'd1;
    localparam logic [2:0] REG_BYPASS_TIME   = 3'd2;
    localparam logic [2:0] REG_CRUISE_SPEED  = 3'd3;
    localparam logic [2:0] REG_REVERSE_SPEED = 3'd4;
    localparam logic [2:0] REG_TURN_SPEED    = 3'd5;

    localparam int unsigned ADDR_W = 5;

    localparam logic [15:0] RST_REVERSE_TIME  = 16'd600;
    localparam logic [15:0] RST_PAUSE_TIME    = 16'd100;
    localparam logic [15:0] RST_BYPASS_TIME   = 16'd1000;
    localparam logic [6:0]  RST_CRUISE_SPEED  = 7'd60;
    localparam logic [6:0]  RST_REVERSE_SPEED = 7'd60;
    localparam logic [6:0]  RST_TURN_SPEED    = 7'd100;

    localparam logic [6:0]  SPEED_MAX = 7'd100;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [1:0]  obstacle_class;
        logic [15:0] ir_left;
        logic [15:0] ir_right;
        logic        turn_busy;
    } t_in_word;

    typedef struct packed {
        logic       cmd_write;
        logic [2:0] drive_cmd;
        logic       speed_write;
        logic [6:0] speed_pct;
        logic [2:0] mode_now;
    } t_out_word;

    function automatic logic [6:0] sat_pct(input logic [6:0] s);
        return (s > SPEED_MAX) ? SPEED_MAX : s;
    endfunction

endpackage

[hw/rtl/oas_in_if.sv]
interface oas_in_if import oas_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input ready, input data);
endinterface

[hw/rtl/oas_out_if.sv]
interface oas_out_if import oas_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input ready, input data);
endinterface

[hw/rtl/obstacle_avoid_sequencer_unit.sv]
// A word accepted is held in the input stage, then in the result register.
// Throughput: one word per cycle unless the output stalls; mode and entry time
// update in the cycle the input stage hands its word to the result register.
// Reset: synchronous, active low; mode goes to idle, entry time to 0,
// configuration registers to their defaults, both stages empty.
module obstacle_avoid_sequencer_unit import oas_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    oas_in_if.sink              i_in,
    oas_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0] r_rev_time;
    logic [15:0] r_pause_time;
    logic [15:0] r_byp_time;
    logic [6:0]  r_cruise_spd;
    logic [6:0]  r_rev_spd;
    logic [6:0]  r_turn_spd;

    logic        r_s1_valid;
    t_in_word    r_s1;
    logic        r_out_valid;
    t_out_word   r_out;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [31:0] r_entry;
    logic [31:0] n_entry;

    logic        s1_adv;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [31:0] elapsed;
    logic        blocked;
    logic        rev_done;
    logic        pause_done;
    logic        byp_done;
    logic [2:0]  turn_cmd;
    t_out_word   res;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_time   <= RST_REVERSE_TIME;
            r_pause_time <= RST_PAUSE_TIME;
            r_byp_time   <= RST_BYPASS_TIME;
            r_cruise_spd <= RST_CRUISE_SPEED;
            r_rev_spd    <= RST_REVERSE_SPEED;
            r_turn_spd   <= RST_TURN_SPEED;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_REVERSE_TIME:  r_rev_time   <= pwdata[15:0];
                REG_PAUSE_TIME:    r_pause_time <= pwdata[15:0];
                REG_BYPASS_TIME:   r_byp_time   <= pwdata[15:0];
                REG_CRUISE_SPEED:  r_cruise_spd <= pwdata[6:0];
                REG_REVERSE_SPEED: r_rev_spd    <= pwdata[6:0];
                REG_TURN_SPEED:    r_turn_spd   <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_REVERSE_TIME:  prdata = {16'd0, r_rev_time};
            REG_PAUSE_TIME:    prdata = {16'd0, r_pause_time};
            REG_BYPASS_TIME:   prdata = {16'd0, r_byp_time};
            REG_CRUISE_SPEED:  prdata = {25'd0, r_cruise_spd};
            REG_REVERSE_SPEED: prdata = {25'd0, r_rev_spd};
            REG_TURN_SPEED:    prdata = {25'd0, r_turn_spd};
            default:           prdata = 32'd0;
        endcase
    end

    // handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_entry     <= 32'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_entry     <= n_entry;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    // step decode
    assign elapsed    = r_s1.now_ms - r_entry;
    assign blocked    = (r_s1.obstacle_class == OBS_FRONT) || (r_s1.obstacle_class == OBS_BOTH);
    assign rev_done   = elapsed >= {16'd0, r_rev_time};
    assign pause_done = elapsed >= {16'd0, r_pause_time};
    assign byp_done   = elapsed >= {16'd0, r_byp_time};
    assign turn_cmd   = (r_s1.ir_left <= r_s1.ir_right) ? CMD_TURN_L : CMD_TURN_R;

    always_comb begin
        n_mode  = r_mode;
        n_entry = r_entry;
        unique case (r_s1.operation)
            OP_START: begin
                n_mode  = MODE_FORWARD;
                n_entry = r_s1.now_ms;
            end
            OP_STOP: begin
                n_mode  = MODE_IDLE;
                n_entry = r_s1.now_ms;
            end
            OP_UPDATE: begin
                unique case (r_mode)
                    MODE_FORWARD: begin
                        if (blocked) begin
                            n_mode  = MODE_REVERSE;
                            n_entry = r_s1.now_ms;
                        end
                    end
                    MODE_REVERSE: begin
                        if (rev_done) begin
                            n_mode  = MODE_PAUSE;
                            n_entry = r_s1.now_ms;
                        end
                    end
                    MODE_PAUSE: begin
                        if (pause_done) begin
                            n_mode  = MODE_TURNING;
                            n_entry = r_s1.now_ms;
                        end
                    end
                    MODE_TURNING: begin
                        if (!r_s1.turn_busy) begin
                            n_mode  = MODE_BYPASS;
                            n_entry = r_s1.now_ms;
                        end
                    end
                    MODE_BYPASS: begin
                        if (blocked) begin
                            n_mode  = MODE_REVERSE;
                            n_entry = r_s1.now_ms;
                        end else if (byp_done) begin
                            n_mode  = MODE_HEADING;
                            n_entry = r_s1.now_ms;
                        end
                    end
                    MODE_HEADING: begin
                        if (!r_s1.turn_busy) begin
                            n_mode  = MODE_FORWARD;
                            n_entry = r_s1.now_ms;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.cmd_write   = 1'b0;
        res.drive_cmd   = CMD_STOP;
        res.speed_write = 1'b0;
        res.speed_pct   = 7'd0;
        res.mode_now    = n_mode;
        unique case (r_s1.operation)
            OP_START: begin
                res.speed_write = 1'b1;
                res.speed_pct   = sat_pct(r_cruise_spd);
            end
            OP_STOP: begin
                res.cmd_write = 1'b1;
            end
            OP_UPDATE: begin
                unique case (r_mode)
                    MODE_FORWARD: begin
                        res.speed_write = 1'b1;
                        res.speed_pct   = sat_pct(r_cruise_spd);
                        res.cmd_write   = 1'b1;
                        res.drive_cmd   = blocked ? CMD_STOP : CMD_FWD;
                    end
                    MODE_REVERSE: begin
                        res.speed_write = 1'b1;
                        res.speed_pct   = sat_pct(r_rev_spd);
                        res.cmd_write   = 1'b1;
                        res.drive_cmd   = rev_done ? CMD_STOP : CMD_REV;
                    end
                    MODE_PAUSE: begin
                        res.cmd_write = 1'b1;
                        if (pause_done) begin
                            res.speed_write = 1'b1;
                            res.speed_pct   = sat_pct(r_turn_spd);
                            res.drive_cmd   = turn_cmd;
                        end
                    end
                    MODE_TURNING: begin
                        if (!r_s1.turn_busy) begin
                            res.speed_write = 1'b1;
                            res.speed_pct   = sat_pct(r_cruise_spd);
                            res.cmd_write   = 1'b1;
                            res.drive_cmd   = CMD_FWD;
                        end
                    end
                    MODE_BYPASS: begin
                        res.speed_write = 1'b1;
                        res.cmd_write   = 1'b1;
                        if (blocked) begin
                            res.speed_pct = sat_pct(r_cruise_spd);
                        end else if (byp_done) begin
                            res.speed_pct = sat_pct(r_turn_spd);
                            res.drive_cmd = CMD_YAW0;
                        end else begin
                            res.speed_pct = sat_pct(r_cruise_spd);
                            res.drive_cmd = CMD_FWD;
                        end
                    end
                    MODE_HEADING: begin
                        if (!r_s1.turn_busy) begin
                            res.speed_write = 1'b1;
                            res.speed_pct   = sat_pct(r_cruise_spd);
                        end
                    end
                    default: begin
                        res.cmd_write = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/oas_checker.sv]
module oas_checker import oas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  t_out_word   i_data
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("stalled result word changed");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_data.mode_now != 3'd7)
        else $error("mode out of range");

    a_speed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_data.speed_pct <= SPEED_MAX)
            && (i_data.speed_write || i_data.speed_pct == 7'd0))
        else $error("speed word malformed");

    a_cmd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_data.cmd_write || i_data.drive_cmd == CMD_STOP)
            && (i_data.drive_cmd <= CMD_YAW0))
        else $error("command word malformed");

endmodule

bind obstacle_avoid_sequencer_unit oas_checker u_oas_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_data  (o_out.data)
);
